// ===== src/sgrg_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants, font table and column map for the scaled glyph row generator
package sgrg_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 160;

    localparam logic [7:0] FIRST_CODE    = 8'd32;
    localparam logic [7:0] LAST_CODE     = 8'd127;
    localparam logic [7:0] FALLBACK_CODE = 8'd63;

    localparam int CELL_COLS   = 6;
    localparam int CELL_ROWS   = 8;
    localparam int GLYPH_COLS  = 5;
    localparam int MAX_SCALE   = 8;
    localparam int SCALE_W     = 4;
    localparam int ROW_BITS_W  = CELL_COLS * MAX_SCALE;
    localparam int FONT_DEPTH  = 96;

    typedef struct packed {
        logic [7:0] char_code;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
    } t_item;

    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        logic [5:0]            row_width;
        logic [5:0]            cell_row;
        logic [7:0]            window_x_end;
        logic [7:0]            window_y_end;
        logic                  last_row;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROWS
    } t_state;

    typedef struct packed {
        logic load;
        logic setup;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic off_screen;
        logic last_row;
        logic out_stall;
    } t_dp_status;

    // glyph column index for each scaled pixel column, one row per scale
    typedef logic [MAX_SCALE-1:0][ROW_BITS_W-1:0][2:0] t_col_map;

    function automatic t_col_map build_col_map();
        t_col_map m;
        int       g;
        int       sub;
        m = '0;
        for (int k = 0; k < MAX_SCALE; k++) begin
            g   = 0;
            sub = 0;
            for (int c = 0; c < ROW_BITS_W; c++) begin
                m[k][c] = (g > 7) ? 3'd7 : 3'(g);
                sub++;
                if (sub == k + 1) begin
                    sub = 0;
                    g++;
                end
            end
        end
        return m;
    endfunction

    localparam t_col_map COL_MAP = build_col_map();

    // one byte per glyph column, bit 0 is the top row
    localparam logic [7:0] FONT_ROM [0:FONT_DEPTH-1][0:GLYPH_COLS-1] = '{
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00},
        '{8'h00, 8'h07, 8'h00, 8'h07, 8'h00}, '{8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14},
        '{8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12}, '{8'h23, 8'h13, 8'h08, 8'h64, 8'h62},
        '{8'h36, 8'h49, 8'h55, 8'h22, 8'h50}, '{8'h00, 8'h05, 8'h03, 8'h00, 8'h00},
        '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00}, '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00},
        '{8'h14, 8'h08, 8'h3E, 8'h08, 8'h14}, '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08},
        '{8'h00, 8'h50, 8'h30, 8'h00, 8'h00}, '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}, '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02},
        '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
        '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
        '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}, '{8'h00, 8'h56, 8'h36, 8'h00, 8'h00},
        '{8'h08, 8'h14, 8'h22, 8'h41, 8'h00}, '{8'h14, 8'h14, 8'h14, 8'h14, 8'h14},
        '{8'h00, 8'h41, 8'h22, 8'h14, 8'h08}, '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06},
        '{8'h32, 8'h49, 8'h79, 8'h41, 8'h3E}, '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E},
        '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22},
        '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41},
        '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01}, '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A},
        '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}, '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00},
        '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01}, '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41},
        '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40}, '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F},
        '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F}, '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E},
        '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06}, '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E},
        '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46}, '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31},
        '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}, '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F},
        '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F}, '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F},
        '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63}, '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07},
        '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}, '{8'h00, 8'h7F, 8'h41, 8'h41, 8'h00},
        '{8'h02, 8'h04, 8'h08, 8'h10, 8'h20}, '{8'h00, 8'h41, 8'h41, 8'h7F, 8'h00},
        '{8'h04, 8'h02, 8'h01, 8'h02, 8'h04}, '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'h00, 8'h01, 8'h02, 8'h04, 8'h00}, '{8'h20, 8'h54, 8'h54, 8'h54, 8'h78},
        '{8'h7F, 8'h48, 8'h44, 8'h44, 8'h38}, '{8'h38, 8'h44, 8'h44, 8'h44, 8'h20},
        '{8'h38, 8'h44, 8'h44, 8'h48, 8'h7F}, '{8'h38, 8'h54, 8'h54, 8'h54, 8'h18},
        '{8'h08, 8'h7E, 8'h09, 8'h01, 8'h02}, '{8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E},
        '{8'h7F, 8'h08, 8'h04, 8'h04, 8'h78}, '{8'h00, 8'h44, 8'h7D, 8'h40, 8'h00},
        '{8'h20, 8'h40, 8'h44, 8'h3D, 8'h00}, '{8'h7F, 8'h10, 8'h28, 8'h44, 8'h00},
        '{8'h00, 8'h41, 8'h7F, 8'h40, 8'h00}, '{8'h7C, 8'h04, 8'h18, 8'h04, 8'h78},
        '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h78}, '{8'h38, 8'h44, 8'h44, 8'h44, 8'h38},
        '{8'h7C, 8'h14, 8'h14, 8'h14, 8'h08}, '{8'h08, 8'h14, 8'h14, 8'h18, 8'h7C},
        '{8'h7C, 8'h08, 8'h04, 8'h04, 8'h08}, '{8'h48, 8'h54, 8'h54, 8'h54, 8'h20},
        '{8'h04, 8'h3F, 8'h44, 8'h40, 8'h20}, '{8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C},
        '{8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C}, '{8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C},
        '{8'h44, 8'h28, 8'h10, 8'h28, 8'h44}, '{8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C},
        '{8'h44, 8'h64, 8'h54, 8'h4C, 8'h44}, '{8'h00, 8'h08, 8'h36, 8'h41, 8'h00},
        '{8'h00, 8'h00, 8'h7F, 8'h00, 8'h00}, '{8'h00, 8'h41, 8'h36, 8'h08, 8'h00},
        '{8'h10, 8'h08, 8'h08, 8'h10, 8'h08}, '{8'h78, 8'h46, 8'h41, 8'h46, 8'h78}
    };

endpackage

// ===== src/scaled_glyph_row_generator.sv =====
`timescale 1ns / 1ps
// top level of the scaled glyph row generator
// Takes one character (code, x, y) per input transfer and draws its 6x8 cell from the 5x7
// font, magnified by the scale register (0 acts as 1, above 8 acts as 8), clipped to the
// right and bottom screen edges. One result transfer leaves per cell row, top to bottom,
// with the row mask, clipped width, window end coordinates and a last flag; a cell starting
// off screen gives none. An item goes through glyph lookup and then clipping before its
// rows; the row sequencer emits one row per cycle, while the output side does not stall,
// into a single output register. The next character is taken as soon as the last row of
// the previous one sits in the output register.
module scaled_glyph_row_generator #(
    parameter int SCREEN_WIDTH  = sgrg_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sgrg_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sgrg_pkg::SCALE_W-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  sgrg_pkg::t_item              i_item,
    output logic                         o_valid,
    input  logic                         i_ready,
    output sgrg_pkg::t_result            o_result
);

    sgrg_pkg::t_dp_cmd    cmd;
    sgrg_pkg::t_dp_status status;

    sgrg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    sgrg_dp #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_ready    (i_ready),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ===== src/sgrg_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine for the scaled glyph row generator
module sgrg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sgrg_pkg::t_dp_status i_status,
    output logic                o_ready,
    output sgrg_pkg::t_dp_cmd   o_cmd
);

    sgrg_pkg::t_state r_state;
    sgrg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgrg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sgrg_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = sgrg_pkg::ST_LOAD;
                end
            end
            sgrg_pkg::ST_LOAD: begin
                // nothing to draw when the cell starts off screen
                if (i_status.off_screen) begin
                    n_state = sgrg_pkg::ST_IDLE;
                end else begin
                    n_state = sgrg_pkg::ST_ROWS;
                end
            end
            sgrg_pkg::ST_ROWS: begin
                if (!i_status.out_stall && i_status.last_row) begin
                    n_state = sgrg_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sgrg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.setup = 1'b0;
        o_cmd.emit  = 1'b0;
        case (r_state)
            sgrg_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            sgrg_pkg::ST_LOAD: begin
                o_cmd.setup = !i_status.off_screen;
            end
            sgrg_pkg::ST_ROWS: begin
                o_cmd.emit = !i_status.out_stall;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/sgrg_dp.sv =====
`timescale 1ns / 1ps
// datapath: scale register, glyph lookup, edge clipping, row counters and output register
module sgrg_dp #(
    parameter int SCREEN_WIDTH  = sgrg_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sgrg_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sgrg_pkg::SCALE_W-1:0]  i_cfg_data,
    input  sgrg_pkg::t_item               i_item,
    input  logic                          i_ready,
    input  sgrg_pkg::t_dp_cmd             i_cmd,
    output sgrg_pkg::t_dp_status          o_status,
    output logic                          o_valid,
    output sgrg_pkg::t_result             o_result
);

    localparam logic [8:0] SCR_W = 9'(SCREEN_WIDTH);
    localparam logic [8:0] SCR_H = 9'(SCREEN_HEIGHT);

    logic [sgrg_pkg::SCALE_W-1:0]   r_scale_cfg;
    logic [sgrg_pkg::GLYPH_COLS-1:0][7:0] r_glyph;
    logic [7:0]                     r_px;
    logic [7:0]                     r_py;
    logic [2:0]                     r_s_m1;
    logic [5:0]                     r_w;
    logic [5:0]                     r_h_m1;
    logic [sgrg_pkg::ROW_BITS_W-1:0] r_wmask;
    logic [5:0]                     r_row;
    logic [2:0]                     r_sub;
    logic [2:0]                     r_grow;
    sgrg_pkg::t_result              r_out;
    logic                           r_out_valid;
    logic                           n_out_valid;

    logic [6:0]                     code_idx;
    logic [2:0]                     cfg_s_m1;
    logic [3:0]                     scale;
    logic [6:0]                     full_w;
    logic [6:0]                     full_h;
    logic [8:0]                     avail_x;
    logic [8:0]                     avail_y;
    logic [5:0]                     clip_w;
    logic [6:0]                     clip_h;
    logic [sgrg_pkg::ROW_BITS_W-1:0] wmask_next;
    logic [7:0]                     g_row;
    logic [sgrg_pkg::ROW_BITS_W-1:0] row_bits;
    logic                           last;

    // codes outside the font fall back to the question mark
    always_comb begin
        if (i_item.char_code < sgrg_pkg::FIRST_CODE || i_item.char_code > sgrg_pkg::LAST_CODE)
        begin
            code_idx = 7'(sgrg_pkg::FALLBACK_CODE - sgrg_pkg::FIRST_CODE);
        end else begin
            code_idx = 7'(i_item.char_code - sgrg_pkg::FIRST_CODE);
        end
    end

    // zero scale acts as one, large scale saturates
    always_comb begin
        if (r_scale_cfg == '0) begin
            cfg_s_m1 = 3'd0;
        end else if (r_scale_cfg > 4'(sgrg_pkg::MAX_SCALE)) begin
            cfg_s_m1 = 3'(sgrg_pkg::MAX_SCALE - 1);
        end else begin
            cfg_s_m1 = 3'(r_scale_cfg - 4'd1);
        end
    end

    assign scale   = {1'b0, r_s_m1} + 4'd1;
    assign full_w  = 7'({scale, 2'b00}) + 7'({scale, 1'b0});
    assign full_h  = {scale, 3'b000};
    assign avail_x = SCR_W - {1'b0, r_px};
    assign avail_y = SCR_H - {1'b0, r_py};
    assign clip_w  = ({2'b00, full_w} < avail_x) ? full_w[5:0] : avail_x[5:0];
    assign clip_h  = ({2'b00, full_h} < avail_y) ? full_h : avail_y[6:0];

    always_comb begin
        for (int c = 0; c < sgrg_pkg::ROW_BITS_W; c++) begin
            wmask_next[c] = 6'(c) < clip_w;
        end
    end

    // glyph row bit of each column, gap and beyond read as blank
    always_comb begin
        g_row = '0;
        for (int k = 0; k < sgrg_pkg::GLYPH_COLS; k++) begin
            g_row[k] = r_glyph[k][r_grow];
        end
    end

    always_comb begin
        for (int c = 0; c < sgrg_pkg::ROW_BITS_W; c++) begin
            row_bits[c] = r_wmask[c] & g_row[sgrg_pkg::COL_MAP[r_s_m1][c]];
        end
    end

    assign last = (r_row == r_h_m1);

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_cfg <= 4'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_scale_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < sgrg_pkg::GLYPH_COLS; k++) begin
                r_glyph[k] <= sgrg_pkg::FONT_ROM[code_idx][k];
            end
            r_px   <= i_item.pos_x;
            r_py   <= i_item.pos_y;
            r_s_m1 <= cfg_s_m1;
        end
        if (i_cmd.setup) begin
            r_w     <= clip_w;
            r_h_m1  <= 6'(clip_h - 7'd1);
            r_wmask <= wmask_next;
            r_row   <= '0;
            r_sub   <= '0;
            r_grow  <= '0;
        end
        if (i_cmd.emit) begin
            r_out.row_bits     <= row_bits;
            r_out.row_width    <= r_w;
            r_out.cell_row     <= r_row;
            r_out.window_x_end <= r_px + 8'(r_w) - 8'd1;
            r_out.window_y_end <= r_py + 8'(r_h_m1);
            r_out.last_row     <= last;
            r_row              <= r_row + 6'd1;
            // step to the next glyph row after scale cell rows
            if (r_sub == r_s_m1) begin
                r_sub  <= '0;
                r_grow <= r_grow + 3'd1;
            end else begin
                r_sub  <= r_sub + 3'd1;
            end
        end
    end

    assign o_status.off_screen = ({1'b0, r_px} >= SCR_W) || ({1'b0, r_py} >= SCR_H);
    assign o_status.last_row   = last;
    assign o_status.out_stall  = r_out_valid && !i_ready;
    assign o_valid             = r_out_valid;
    assign o_result            = r_out;

endmodule

// ===== src/sgrg_chk.sv =====
`timescale 1ns / 1ps
// port-level checker for the scaled glyph row generator, bound to the top level
module sgrg_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input sgrg_pkg::t_result            o_result
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result))
        else $error("result changed while stalled");

    // mid character the block takes no new item
    a_busy_mid_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last_row |-> !o_ready)
        else $error("input ready while a character is still being drawn");

    // nothing lit at or beyond the clipped width
    a_width_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.row_width != 6'd0
                    && (o_result.row_bits >> o_result.row_width) == '0)
        else $error("row bits beyond row width");

    // rows of one character come in order
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_result.last_row |=>
            !o_valid || o_result.cell_row == 6'($past(o_result.cell_row) + 6'd1))
        else $error("cell row out of sequence");

endmodule

bind scaled_glyph_row_generator sgrg_chk u_chk (.*);

// ===== tb/sv/scaled_glyph_row_generator_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the scaled glyph row generator: directed table, then random phases
module scaled_glyph_row_generator_tb;

    localparam int SCR_W       = 128;
    localparam int SCR_H       = 160;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYC  = 16;
    localparam int TAIL_CYC    = 100;
    localparam int N_PHASES    = 6;
    localparam int PHASE_CHARS = 26;
    localparam int MAX_PRINTED = 40;

    localparam logic [7:0] CODE_FIRST = 8'd32;
    localparam logic [7:0] CODE_LAST  = 8'd127;
    localparam logic [7:0] CODE_QMARK = 8'd63;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    // five glyph columns per code, column 0 in the top byte, bit 0 of a byte is the top row
    localparam logic [39:0] FONT_COLS [96] = '{
        40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
        40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
        40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
        40'h00_50_30_00_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
        40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
        40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
        40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
        40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
        40'h32_49_79_41_3E, 40'h7E_11_11_11_7E, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
        40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
        40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
        40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
        40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
        40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
        40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
        40'h02_04_08_10_20, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
        40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
        40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
        40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h7F_10_28_44_00,
        40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
        40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
        40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
        40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h00_08_36_41_00,
        40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08, 40'h78_46_41_46_78
    };

    // typed rows are blank cells (or off screen) whose geometry is given directly
    typedef struct packed {
        logic [3:0] scale;
        logic [7:0] code;
        logic [7:0] x;
        logic [7:0] y;
        logic       typed;
        logic [5:0] t_w;
        logic [6:0] t_h;
    } t_char_case;

    localparam int N_DIR = 23;
    localparam t_char_case DIR_TBL [N_DIR] = '{
        '{4'd1,  8'd32,  8'd0,   8'd0,   1'b1, 6'd6,  7'd8},
        '{4'd1,  8'd33,  8'd0,   8'd0,   1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd127, 8'd10,  8'd10,  1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd126, 8'd20,  8'd0,   1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd0,   8'd30,  8'd40,  1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd31,  8'd40,  8'd40,  1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd128, 8'd50,  8'd40,  1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd255, 8'd255, 8'd255, 1'b1, 6'd0,  7'd0},
        '{4'd1,  8'd65,  8'd127, 8'd0,   1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd87,  8'd0,   8'd159, 1'b0, 6'd0,  7'd0},
        '{4'd1,  8'd72,  8'd128, 8'd0,   1'b1, 6'd0,  7'd0},
        '{4'd1,  8'd72,  8'd0,   8'd160, 1'b1, 6'd0,  7'd0},
        '{4'd1,  8'd64,  8'd122, 8'd152, 1'b0, 6'd0,  7'd0},
        '{4'd8,  8'd77,  8'd0,   8'd0,   1'b0, 6'd0,  7'd0},
        '{4'd8,  8'd32,  8'd100, 8'd120, 1'b1, 6'd28, 7'd40},
        '{4'd8,  8'd35,  8'd127, 8'd159, 1'b0, 6'd0,  7'd0},
        '{4'd0,  8'd66,  8'd5,   8'd5,   1'b0, 6'd0,  7'd0},
        '{4'd0,  8'd32,  8'd0,   8'd0,   1'b1, 6'd6,  7'd8},
        '{4'd15, 8'd90,  8'd80,  8'd96,  1'b0, 6'd0,  7'd0},
        '{4'd15, 8'd32,  8'd81,  8'd97,  1'b1, 6'd47, 7'd63},
        '{4'd3,  8'd103, 8'd200, 8'd3,   1'b1, 6'd0,  7'd0},
        '{4'd3,  8'd106, 8'd60,  8'd50,  1'b0, 6'd0,  7'd0},
        '{4'd3,  8'd127, 8'd126, 8'd150, 1'b0, 6'd0,  7'd0}
    };

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_cfg_we   = 1'b0;
    logic [3:0]                i_cfg_data = 4'd0;
    logic                      i_valid    = 1'b0;
    logic                      o_ready;
    sgrg_pkg::t_item           i_item     = '0;
    logic                      o_valid;
    logic                      i_ready    = 1'b0;
    sgrg_pkg::t_result         o_result;

    sgrg_pkg::t_result         pending_rows [$];
    sgrg_pkg::t_result         want_row;
    logic [3:0]                scale_cfg  = 4'd1;
    int                        err_count  = 0;
    int                        cyc_count  = 0;
    int                        burst_left = 0;
    int                        rx_left    = 0;
    t_rx_mode                  rx_mode    = RX_OPEN;

    scaled_glyph_row_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_err(input string msg);
        if (err_count < MAX_PRINTED)
            $display("[%0d] mismatch: %s", cyc_count, msg);
        err_count++;
    endtask

    // expected rows of one character at the current scale, returns how many
    function automatic int draw_glyph_rows(input logic [7:0] code, input logic [7:0] x,
                                           input logic [7:0] y);
        int unsigned       s;
        int unsigned       w;
        int unsigned       h;
        int unsigned       grow;
        int unsigned       gcol;
        logic [39:0]       glyph;
        logic [7:0]        colbyte;
        logic [47:0]       bits;
        sgrg_pkg::t_result row;
        s = (scale_cfg == 4'd0) ? 1 : ((scale_cfg > 4'd8) ? 8 : int'(scale_cfg));
        if (code < CODE_FIRST || code > CODE_LAST)
            glyph = FONT_COLS[CODE_QMARK - CODE_FIRST];
        else
            glyph = FONT_COLS[code - CODE_FIRST];
        if (x >= SCR_W || y >= SCR_H)
            return 0;
        w = 6 * s;
        h = 8 * s;
        if (x + w > SCR_W)
            w = SCR_W - x;
        if (y + h > SCR_H)
            h = SCR_H - y;
        for (int unsigned r = 0; r < h; r++) begin
            grow = r / s;
            bits = '0;
            for (int unsigned c = 0; c < w; c++) begin
                // the sixth scaled column is the gap and stays clear
                if (c < 5 * s) begin
                    gcol    = c / s;
                    colbyte = glyph[39 - 8 * gcol -: 8];
                    bits[c] = colbyte[grow];
                end
            end
            row.row_bits     = bits;
            row.row_width    = 6'(w);
            row.cell_row     = 6'(r);
            row.window_x_end = 8'(x + w - 1);
            row.window_y_end = 8'(y + h - 1);
            row.last_row     = (r + 1 == h);
            pending_rows.push_back(row);
        end
        return int'(h);
    endfunction

    // offers one character in bursts with random gaps; returns once it is transferred
    task automatic send_char(input logic [7:0] code, input logic [7:0] x, input logic [7:0] y);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 10);
        end
        i_valid <= 1'b1;
        i_item  <= '{char_code: code, pos_x: x, pos_y: y};
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
    endtask

    // an off-screen character leaves no row behind, so allow it to clear the pipeline too
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_scale(input logic [3:0] val);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        scale_cfg = val;
    endtask

    // receiver stall pattern, independent of the sender
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   i_ready <= 1'b1;
            RX_HALF:   i_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
            default:   i_ready <= (rx_left % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rows.size() == 0) begin
                report_err($sformatf("row transfer with nothing expected, cell_row %0d",
                                     o_result.cell_row));
            end else begin
                want_row = pending_rows.pop_front();
                if (o_result.row_bits !== want_row.row_bits)
                    report_err($sformatf("row_bits %h, expected %h",
                                         o_result.row_bits, want_row.row_bits));
                if (o_result.row_width !== want_row.row_width)
                    report_err($sformatf("row_width %0d, expected %0d",
                                         o_result.row_width, want_row.row_width));
                if (o_result.cell_row !== want_row.cell_row)
                    report_err($sformatf("cell_row %0d, expected %0d",
                                         o_result.cell_row, want_row.cell_row));
                if (o_result.window_x_end !== want_row.window_x_end)
                    report_err($sformatf("window_x_end %0d, expected %0d",
                                         o_result.window_x_end, want_row.window_x_end));
                if (o_result.window_y_end !== want_row.window_y_end)
                    report_err($sformatf("window_y_end %0d, expected %0d",
                                         o_result.window_y_end, want_row.window_y_end));
                if (o_result.last_row !== want_row.last_row)
                    report_err($sformatf("last_row %b, expected %b",
                                         o_result.last_row, want_row.last_row));
            end
        end
    end

    always @(posedge i_clk) begin
        cyc_count++;
        if (cyc_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        sgrg_pkg::t_result blank;
        t_char_case        cc;
        logic [7:0]        code;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [3:0]        phase_scale;
        int                pick;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; the first rows run on the reset scale
        for (int k = 0; k < N_DIR; k++) begin
            cc = DIR_TBL[k];
            if (cc.scale != scale_cfg)
                set_scale(cc.scale);
            send_char(cc.code, cc.x, cc.y);
            if (cc.typed) begin
                for (int r = 0; r < int'(cc.t_h); r++) begin
                    blank.row_bits     = '0;
                    blank.row_width    = cc.t_w;
                    blank.cell_row     = 6'(r);
                    blank.window_x_end = 8'(cc.x + cc.t_w - 1);
                    blank.window_y_end = 8'(cc.y + cc.t_h - 1);
                    blank.last_row     = (r + 1 == int'(cc.t_h));
                    pending_rows.push_back(blank);
                end
            end else begin
                void'(draw_glyph_rows(cc.code, cc.x, cc.y));
            end
        end

        // random phases, each on its own scale
        for (int p = 0; p < N_PHASES; p++) begin
            if ($urandom_range(0, 3) == 0)
                phase_scale = 4'($urandom_range(0, 15));
            else
                phase_scale = 4'($urandom_range(1, 8));
            set_scale(phase_scale);
            for (int n = 0; n < PHASE_CHARS; n++) begin
                if ($urandom_range(0, 9) < 7)
                    code = 8'($urandom_range(32, 127));
                else
                    code = 8'($urandom_range(0, 255));
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    x = 8'($urandom_range(0, SCR_W - 1));
                    y = 8'($urandom_range(0, SCR_H - 1));
                end else if (pick < 8) begin
                    // close to the right and bottom edges so clipping kicks in
                    x = 8'(SCR_W - $urandom_range(1, 48));
                    y = 8'(SCR_H - $urandom_range(1, 64));
                end else begin
                    x = 8'($urandom_range(0, 255));
                    y = 8'($urandom_range(0, 255));
                end
                send_char(code, x, y);
                void'(draw_glyph_rows(code, x, y));
            end
        end

        wait_idle();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (pending_rows.size() != 0)
            report_err($sformatf("%0d rows never arrived", pending_rows.size()));
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== scaled_glyph_row_generator.f =====
src/sgrg_pkg.sv
src/sgrg_ctrl.sv
src/sgrg_dp.sv
src/scaled_glyph_row_generator.sv
src/sgrg_chk.sv
tb/sv/scaled_glyph_row_generator_tb.sv
